// ----- rtl/core/bspe_pkg.sv -----
`default_nettype none

package bspe_pkg;

	// field widths
	localparam int ANGLE_WIDTH = 16;
	localparam int OUTPUT_WIDTH = 24;
	localparam int RADIUS_WIDTH = 16;
	localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 16'd256;

	// angle to q.28 radians
	localparam int ANGLE_SHIFT = 30 - ANGLE_WIDTH;

	// q.28 constants
	localparam logic [31:0] FX_ONE = 32'd268435456;
	localparam logic [31:0] FX_PI = 32'd843314857;
	localparam logic [31:0] FX_TWO_PI = 32'd1686629714;
	localparam logic [31:0] FX_HALF_PI = 32'd421657428;

	typedef logic signed [31:0] fx_t;
	typedef logic signed [63:0] fx_prod_t;

	localparam fx_t FX_B = 32'sd379625062;

	// sine series: divisors and their truncated reciprocals scaled by 2^32
	localparam int SIN_STEPS = 5;
	localparam int SIN_LAT = 20;
	localparam logic [6:0] SIN_DIV [SIN_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [29:0] SIN_RECIP [SIN_STEPS] = '{
		30'(64'd4294967296 / 64'd110),
		30'(64'd4294967296 / 64'd72),
		30'(64'd4294967296 / 64'd42),
		30'(64'd4294967296 / 64'd20),
		30'(64'd4294967296 / 64'd6)
	};

	// rounding divider widths
	localparam int NUM_W = 53;
	localparam int DEN_W = 32;

	typedef struct packed {
		logic [ANGLE_WIDTH-1:0] u_angle;
		logic [ANGLE_WIDTH-1:0] v_angle;
	} angle_t;

	typedef struct packed {
		logic signed [OUTPUT_WIDTH-1:0] point_x;
		logic signed [OUTPUT_WIDTH-1:0] point_y;
		logic signed [OUTPUT_WIDTH-1:0] point_z;
	} point_t;

	// q.28 product back to q.28, floor
	function automatic fx_t fx_hi(input fx_prod_t p);
		return fx_t'(p[59:28]);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bspe_sin.sv -----
`default_nettype none

module bspe_sin (
	input  logic            clk,
	input  logic            en,
	input  logic [31:0]     angle,
	output bspe_pkg::fx_t   sine
);

	logic [30:0] r_s1;
	logic        neg2a;
	logic [29:0] r2a;
	logic [28:0] r2;
	logic [28:0] r_s2;
	logic        neg_s2;
	logic [57:0] sq_s3;
	logic [28:0] r_s3;
	logic        neg_s3;
	logic [28:0] s_ch [bspe_pkg::SIN_STEPS+1];
	logic [29:0] x2_ch [bspe_pkg::SIN_STEPS+1];
	logic [28:0] r_ch [bspe_pkg::SIN_STEPS+1];
	logic        neg_ch [bspe_pkg::SIN_STEPS+1];
	logic [57:0] mag_prod_s19;
	logic        neg_s19;
	bspe_pkg::fx_t mag_x;

	// reduce modulo two pi
	always_ff @(posedge clk) begin
		if (en) begin
			if (angle >= bspe_pkg::FX_TWO_PI)
				r_s1 <= 31'(angle - bspe_pkg::FX_TWO_PI);
			else
				r_s1 <= angle[30:0];
		end
	end

	// fold into the first quadrant
	always_comb begin
		neg2a = (32'(r_s1) >= bspe_pkg::FX_PI);
		r2a = neg2a ? 30'(32'(r_s1) - bspe_pkg::FX_PI) : r_s1[29:0];
		r2 = (32'(r2a) > bspe_pkg::FX_HALF_PI) ? 29'(bspe_pkg::FX_PI - 32'(r2a)) : r2a[28:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2 <= r2;
			neg_s2 <= neg2a;
		end
	end

	// square of the folded angle
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= 58'(r_s2) * 58'(r_s2);
			r_s3 <= r_s2;
			neg_s3 <= neg_s2;
		end
	end

	assign s_ch[0] = 29'(bspe_pkg::FX_ONE);
	assign x2_ch[0] = sq_s3[57:28];
	assign r_ch[0] = r_s3;
	assign neg_ch[0] = neg_s3;

	// nested series, three stages per term
	for (genvar i = 0; i < bspe_pkg::SIN_STEPS; i++) begin : g_term
		logic [58:0] prod_sa;
		logic [29:0] x2_sa;
		logic [28:0] r_sa;
		logic        neg_sa;
		logic [29:0] p_sb;
		logic [59:0] pm_sb;
		logic [29:0] x2_sb;
		logic [28:0] r_sb;
		logic        neg_sb;
		logic [27:0] q0;
		logic [34:0] qk;
		logic [29:0] rem;
		logic [28:0] q;
		logic [28:0] s_sc;
		logic [29:0] x2_sc;
		logic [28:0] r_sc;
		logic        neg_sc;

		always_ff @(posedge clk) begin
			if (en) begin
				prod_sa <= 59'(x2_ch[i]) * 59'(s_ch[i]);
				x2_sa <= x2_ch[i];
				r_sa <= r_ch[i];
				neg_sa <= neg_ch[i];
			end
		end

		// reciprocal multiply, may come out one low
		always_ff @(posedge clk) begin
			if (en) begin
				p_sb <= prod_sa[57:28];
				pm_sb <= 60'(prod_sa[57:28]) * 60'(bspe_pkg::SIN_RECIP[i]);
				x2_sb <= x2_sa;
				r_sb <= r_sa;
				neg_sb <= neg_sa;
			end
		end

		// correct the quotient and form the next term
		always_comb begin
			q0 = pm_sb[59:32];
			qk = 35'(q0) * 35'(bspe_pkg::SIN_DIV[i]);
			rem = p_sb - qk[29:0];
			q = 29'(q0) + 29'(rem >= 30'(bspe_pkg::SIN_DIV[i]));
		end

		always_ff @(posedge clk) begin
			if (en) begin
				s_sc <= 29'(bspe_pkg::FX_ONE) - q;
				x2_sc <= x2_sb;
				r_sc <= r_sb;
				neg_sc <= neg_sb;
			end
		end

		assign s_ch[i+1] = s_sc;
		assign x2_ch[i+1] = x2_sc;
		assign r_ch[i+1] = r_sc;
		assign neg_ch[i+1] = neg_sc;
	end

	// magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			mag_prod_s19 <= 58'(r_ch[bspe_pkg::SIN_STEPS]) * 58'(s_ch[bspe_pkg::SIN_STEPS]);
			neg_s19 <= neg_ch[bspe_pkg::SIN_STEPS];
		end
	end

	assign mag_x = bspe_pkg::fx_t'({3'b000, mag_prod_s19[56:28]});

	// apply sign
	always_ff @(posedge clk) begin
		if (en)
			sine <= neg_s19 ? -mag_x : mag_x;
	end

endmodule

`default_nettype wire

// ----- rtl/core/bspe_div.sv -----
`default_nettype none

module bspe_div #(
	parameter int NUM_W = bspe_pkg::NUM_W,
	parameter int DEN_W = bspe_pkg::DEN_W,
	parameter int Q_W = bspe_pkg::OUTPUT_WIDTH
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [NUM_W-1:0]      num,
	input  logic [DEN_W-1:0]      den,
	input  logic                  neg,
	output logic signed [Q_W-1:0] quot
);

	localparam int HI_W = NUM_W - Q_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
	localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	logic [CMP_W-1:0] hi_x;
	logic [CMP_W-1:0] den_x;
	logic [DEN_W-1:0] rem_ch [Q_W+1];
	logic [Q_W-1:0]   lo_ch [Q_W+1];
	logic [DEN_W-1:0] den_ch [Q_W+1];
	logic             neg_ch [Q_W+1];
	logic             ovf_ch [Q_W+1];
	logic [DEN_W-1:0] rem_s0;
	logic [Q_W-1:0]   lo_s0;
	logic [DEN_W-1:0] den_s0;
	logic             neg_s0;
	logic             ovf_s0;
	logic [Q_W-1:0]   q;
	logic             big_pos;
	logic             big_neg;

	// quotient too wide when the top part already reaches the divisor
	assign hi_x = CMP_W'(num[NUM_W-1:Q_W]);
	assign den_x = CMP_W'(den);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s0 <= DEN_W'(hi_x);
			lo_s0 <= num[Q_W-1:0];
			den_s0 <= den;
			neg_s0 <= neg;
			ovf_s0 <= (hi_x >= den_x);
		end
	end

	assign rem_ch[0] = rem_s0;
	assign lo_ch[0] = lo_s0;
	assign den_ch[0] = den_s0;
	assign neg_ch[0] = neg_s0;
	assign ovf_ch[0] = ovf_s0;

	// restoring division, one quotient bit per stage
	for (genvar i = 0; i < Q_W; i++) begin : g_step
		logic [DEN_W:0]   t;
		logic [DEN_W:0]   diff;
		logic             ge;
		logic [DEN_W-1:0] rem_s;
		logic [Q_W-1:0]   lo_s;
		logic [DEN_W-1:0] den_s;
		logic             neg_s;
		logic             ovf_s;

		always_comb begin
			t = {rem_ch[i], lo_ch[i][Q_W-1]};
			ge = (t >= {1'b0, den_ch[i]});
			diff = t - {1'b0, den_ch[i]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
				lo_s <= {lo_ch[i][Q_W-2:0], ge};
				den_s <= den_ch[i];
				neg_s <= neg_ch[i];
				ovf_s <= ovf_ch[i];
			end
		end

		assign rem_ch[i+1] = rem_s;
		assign lo_ch[i+1] = lo_s;
		assign den_ch[i+1] = den_s;
		assign neg_ch[i+1] = neg_s;
		assign ovf_ch[i+1] = ovf_s;
	end

	// sign and saturation
	always_comb begin
		q = lo_ch[Q_W];
		big_pos = ovf_ch[Q_W] || q[Q_W-1];
		big_neg = ovf_ch[Q_W] || (q[Q_W-1] && (q[Q_W-2:0] != '0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_ch[Q_W])
				quot <= big_neg ? Q_MIN : -q;
			else
				quot <= big_pos ? Q_MAX : q;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/boy_surface_point_eval.sv -----
`default_nettype none

// Boy's surface vertex evaluator. Each request carries two angles u and v (unsigned
// Q2.14 radians) and yields one point x, y, z in signed Q11.12, scaled by the radius
// register (unsigned Q8.8, reset 1.0) with the radius already taken off z; results
// saturate. The block is a fixed pipeline of 30 + OUTPUT_WIDTH = 54 stages: input
// register, eight parallel 20-stage sine units, seven stages of products, and a
// restoring divider that resolves one quotient bit per stage. A new request enters
// every cycle and results leave in order; a stall on the result side holds the whole
// pipeline. Write the radius only while the pipeline is empty.
module boy_surface_point_eval (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 radius_we,
	input  logic [bspe_pkg::RADIUS_WIDTH-1:0]    radius_wdata,
	input  logic                                 angle_valid,
	output logic                                 angle_stall,
	input  bspe_pkg::angle_t                     angle,
	output logic                                 point_valid,
	input  logic                                 point_stall,
	output bspe_pkg::point_t                     point
);

	localparam int OW = bspe_pkg::OUTPUT_WIDTH;
	localparam int AW = bspe_pkg::ANGLE_WIDTH;
	localparam int NW = bspe_pkg::NUM_W;
	localparam int DW = bspe_pkg::DEN_W;
	localparam int TOTAL = 30 + OW;

	logic [bspe_pkg::RADIUS_WIDTH-1:0] radius_q;
	logic [TOTAL-1:0] vld_s;
	logic adv;

	logic [AW-1:0] u_s1;
	logic [AW-1:0] v_s1;
	logic [31:0] u28;
	logic [31:0] v28;
	logic [31:0] arg [8];
	bspe_pkg::fx_t trig [8];

	bspe_pkg::fx_prod_t p_cs2v_s22, p_cc2v_s22, p_bsu_s22, p_cucu_s22, p_den_s22;
	bspe_pkg::fx_t cu_s22, sv_s22, cv_s22;
	bspe_pkg::fx_t bsu, den_raw;
	bspe_pkg::fx_t a_s23, c_s23, den_s23, cu_s23;
	bspe_pkg::fx_prod_t m_sv_s23, m_cv_s23, m_nz_s23;
	bspe_pkg::fx_t tx_s24, ty_s24, nz_s24, den_s24, cu_s24;
	bspe_pkg::fx_prod_t p_nx_s25, p_ny_s25;
	bspe_pkg::fx_t dz_s25, den_s25;
	bspe_pkg::fx_t nx, ny;
	logic [31:0] mag_x_s26, mag_y_s26, mag_z_s26, den_s26;
	logic neg_x_s26, neg_y_s26, neg_z_s26;
	logic [47:0] px_s27, py_s27, pz_s27;
	logic [31:0] den_s27, den3_s27;
	logic neg_x_s27, neg_y_s27, neg_z_s27;
	logic [NW-1:0] num_x_s28, num_y_s28, num_z_s28;
	logic [DW-1:0] den_s28, den3_s28;
	logic neg_x_s28, neg_y_s28, neg_z_s28;
	logic signed [OW-1:0] qx, qy, qz;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= bspe_pkg::RADIUS_RESET;
		else if (radius_we)
			radius_q <= radius_wdata;
	end

	// global advance, valid bits move with the data
	assign adv = !(vld_s[TOTAL-1] && point_stall);
	assign angle_stall = !adv;
	assign point_valid = vld_s[TOTAL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[TOTAL-2:0], angle_valid};
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= angle.u_angle;
			v_s1 <= angle.v_angle;
		end
	end

	// sine arguments, cosines as quarter-turn shifts
	always_comb begin
		u28 = 32'(u_s1) << bspe_pkg::ANGLE_SHIFT;
		v28 = 32'(v_s1) << bspe_pkg::ANGLE_SHIFT;
		arg[0] = u28 + bspe_pkg::FX_HALF_PI;
		arg[1] = u28;
		arg[2] = u28 << 1;
		arg[3] = v28;
		arg[4] = v28 + bspe_pkg::FX_HALF_PI;
		arg[5] = v28 << 1;
		arg[6] = (v28 << 1) + bspe_pkg::FX_HALF_PI;
		arg[7] = (v28 << 1) + v28;
	end

	for (genvar i = 0; i < 8; i++) begin : g_sin
		bspe_sin u_sin (
			.clk   (clk),
			.en    (adv),
			.angle (arg[i]),
			.sine  (trig[i])
		);
	end

	// first products: cu, su, s2u, sv, cv, s2v, c2v, s3v
	always_ff @(posedge clk) begin
		if (adv) begin
			p_cs2v_s22 <= trig[0] * trig[5];
			p_cc2v_s22 <= trig[0] * trig[6];
			p_bsu_s22 <= bspe_pkg::FX_B * trig[1];
			p_cucu_s22 <= trig[0] * trig[0];
			p_den_s22 <= trig[2] * trig[7];
			cu_s22 <= trig[0];
			sv_s22 <= trig[3];
			cv_s22 <= trig[4];
		end
	end

	// denominator and second products
	always_comb begin
		bsu = bspe_pkg::fx_hi(p_bsu_s22);
		den_raw = bspe_pkg::FX_B - bspe_pkg::fx_hi(p_den_s22);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s23 <= bspe_pkg::fx_hi(p_cs2v_s22);
			c_s23 <= bspe_pkg::fx_hi(p_cc2v_s22);
			m_sv_s23 <= bsu * sv_s22;
			m_cv_s23 <= bsu * cv_s22;
			m_nz_s23 <= bspe_pkg::FX_B * bspe_pkg::fx_hi(p_cucu_s22);
			den_s23 <= (den_raw <= 0) ? bspe_pkg::fx_t'(1) : den_raw;
			cu_s23 <= cu_s22;
		end
	end

	// inner sums
	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s24 <= a_s23 - bspe_pkg::fx_hi(m_sv_s23);
			ty_s24 <= c_s23 + bspe_pkg::fx_hi(m_cv_s23);
			nz_s24 <= bspe_pkg::fx_hi(m_nz_s23);
			den_s24 <= den_s23;
			cu_s24 <= cu_s23;
		end
	end

	// outer cos u factor, z numerator
	always_ff @(posedge clk) begin
		if (adv) begin
			p_nx_s25 <= tx_s24 * cu_s24;
			p_ny_s25 <= ty_s24 * cu_s24;
			dz_s25 <= nz_s24 - den_s24;
			den_s25 <= den_s24;
		end
	end

	// split sign and magnitude
	always_comb begin
		nx = bspe_pkg::fx_hi(p_nx_s25);
		ny = bspe_pkg::fx_hi(p_ny_s25);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_x_s26 <= nx < 0;
			neg_y_s26 <= ny < 0;
			neg_z_s26 <= dz_s25 < 0;
			mag_x_s26 <= (nx < 0) ? 32'(-nx) : 32'(nx);
			mag_y_s26 <= (ny < 0) ? 32'(-ny) : 32'(ny);
			mag_z_s26 <= (dz_s25 < 0) ? 32'(-dz_s25) : 32'(dz_s25);
			den_s26 <= 32'(den_s25);
		end
	end

	// radius scaling
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s27 <= 48'(radius_q) * 48'(mag_x_s26);
			py_s27 <= 48'(radius_q) * 48'(mag_y_s26);
			pz_s27 <= 48'(radius_q) * 48'(mag_z_s26);
			den_s27 <= den_s26;
			den3_s27 <= (den_s26 << 1) + den_s26;
			neg_x_s27 <= neg_x_s26;
			neg_y_s27 <= neg_y_s26;
			neg_z_s27 <= neg_z_s26;
		end
	end

	// dividends with half the divisor for round to nearest
	always_ff @(posedge clk) begin
		if (adv) begin
			num_x_s28 <= (NW'(px_s27) << 5) + NW'(den3_s27 >> 1);
			num_y_s28 <= (NW'(py_s27) << 5) + NW'(den3_s27 >> 1);
			num_z_s28 <= (NW'(pz_s27) << 4) + NW'(den_s27 >> 1);
			den_s28 <= den_s27;
			den3_s28 <= den3_s27;
			neg_x_s28 <= neg_x_s27;
			neg_y_s28 <= neg_y_s27;
			neg_z_s28 <= neg_z_s27;
		end
	end

	bspe_div #(.NUM_W(NW), .DEN_W(DW), .Q_W(OW)) u_div_x (
		.clk  (clk),
		.en   (adv),
		.num  (num_x_s28),
		.den  (den3_s28),
		.neg  (neg_x_s28),
		.quot (qx)
	);

	bspe_div #(.NUM_W(NW), .DEN_W(DW), .Q_W(OW)) u_div_y (
		.clk  (clk),
		.en   (adv),
		.num  (num_y_s28),
		.den  (den3_s28),
		.neg  (neg_y_s28),
		.quot (qy)
	);

	bspe_div #(.NUM_W(NW), .DEN_W(DW), .Q_W(OW)) u_div_z (
		.clk  (clk),
		.en   (adv),
		.num  (num_z_s28),
		.den  (den_s28),
		.neg  (neg_z_s28),
		.quot (qz)
	);

	always_comb begin
		point.point_x = qx;
		point.point_y = qy;
		point.point_z = qz;
	end

	// input held back only by a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		angle_stall |-> (point_valid && point_stall))
		else $error("input stalled without a stalled result");

	// denominator always positive after clamping
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[22] |-> (den_s23 > 0))
		else $error("denominator not positive");

	// radius write lands
	assert property (@(posedge clk) disable iff (!arst_n)
		radius_we |=> (radius_q == $past(radius_wdata)))
		else $error("radius write lost");

endmodule

`default_nettype wire
